// ===== src/drawdown_tracker_core_defines.svh =====
// Assertion macros used by the checker file of the drawdown tracker.
// No other dependencies; include with the bare file name.
`ifndef DRAWDOWN_TRACKER_CORE_DEFINES_SVH
`define DRAWDOWN_TRACKER_CORE_DEFINES_SVH

// Plain property, sampled on the rising edge and disabled while in reset.
`define DDT_ASSERT(lbl, clk_e, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_e) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define DDT_ASSERT_NEXT(lbl, clk_e, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk_e) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/ddt_pkg.sv =====
// Package of the drawdown tracker: widths, word types, status codes and the
// controller command and status groups. No dependencies.
`default_nettype none

package ddt_pkg;

	localparam int RET_W   = 32;
	localparam int VAL_W   = 45;
	localparam int TOT_W   = 58;
	localparam int CNT_W   = 13;
	localparam int DVD_W   = 57;
	localparam int MAX_OBS_DEFAULT = 4096;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_SHORT    = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [RET_W-1:0] sample_return;
		logic                    is_last;
	} in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] drawdown;
		logic [VAL_W-1:0]        worst_drawdown;
		logic [VAL_W-1:0]        mean_drawdown;
		logic [CNT_W-1:0]        peak_index;
		logic [CNT_W-1:0]        trough_index;
		logic [CNT_W-1:0]        recovery_index;
		logic [CNT_W-1:0]        drawdown_duration;
		logic [CNT_W-1:0]        sample_count;
		logic [1:0]              status;
		logic                    last_result;
	} out_word_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic load_out;
		logic with_avg;
		logic clear;
		logic div_start;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== src/ddt_div.sv =====
// Restoring divider for the average drawdown: one quotient bit per cycle.
// Depends on ddt_pkg for the operand widths.
`default_nettype none

module ddt_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [ddt_pkg::DVD_W-1:0] dividend,
	input  wire logic [ddt_pkg::CNT_W-1:0] divisor,
	output logic                          done,
	output logic [ddt_pkg::DVD_W-1:0]      quotient
);
	import ddt_pkg::*;

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;

	logic [CNT_W:0]    shifted;
	logic [CNT_W:0]    trial;
	logic              qbit;

	always_comb begin
		shifted = {rem_q, dvd_q[DVD_W-1]};
		trial   = shifted - {1'b0, dsr_q};
		qbit    = !trial[CNT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder always stays below the divisor, so it fits in CNT_W bits.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= qbit ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

// ===== src/ddt_dp.sv =====
// Datapath of the drawdown tracker: series state, the output register and
// the divider for the average. Depends on ddt_pkg and ddt_div.
`default_nettype none

module ddt_dp #(
	parameter int MAX_OBS = ddt_pkg::MAX_OBS_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ddt_pkg::in_word_t  in_data,
	input  wire ddt_pkg::ctrl_cmd_t cmd,
	output ddt_pkg::ctrl_sts_t      sts,
	output ddt_pkg::out_word_t      out_data
);
	import ddt_pkg::*;

	logic signed [VAL_W-1:0] cum_q, peak_q, plevel_q, last_dd_q;
	logic [VAL_W-1:0]        deep_q;
	logic signed [TOT_W-1:0] total_q;
	logic [CNT_W-1:0]        peak_idx_q, trough_q, ppos_q, rec_q, cnt_q;
	logic                    rec_vld_q, ovf_q, last_q, drop_q, first_q;
	out_word_t               out_q;

	logic signed [VAL_W-1:0] ret_ext;
	logic signed [VAL_W-1:0] diff;
	logic signed [VAL_W-1:0] dd;
	logic [VAL_W-1:0]        mag;
	logic                    ge, deeper, regained;
	logic [TOT_W-1:0]        neg_total;
	logic [DVD_W-1:0]        quotient;
	logic                    div_done;
	status_t                 status;

	always_comb begin
		ret_ext   = {{(VAL_W-RET_W){in_data.sample_return[RET_W-1]}}, in_data.sample_return};
		diff      = cum_q - peak_q;
		ge        = first_q || !diff[VAL_W-1];
		dd        = ge ? '0 : diff;
		mag       = '0 - dd;
		deeper    = mag > deep_q;
		regained  = !rec_vld_q && (cnt_q > trough_q) && (cum_q >= plevel_q);
		neg_total = '0 - total_q;
		if (ovf_q) begin
			status = STATUS_OVERFLOW;
		end else if (cnt_q < CNT_W'(2)) begin
			status = STATUS_SHORT;
		end else begin
			status = STATUS_OK;
		end
	end

	ddt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (neg_total[DVD_W-1:0]),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_q      <= '0;
			peak_q     <= '0;
			peak_idx_q <= '0;
			deep_q     <= '0;
			trough_q   <= '0;
			ppos_q     <= '0;
			plevel_q   <= '0;
			rec_q      <= '0;
			rec_vld_q  <= 1'b0;
			total_q    <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			last_dd_q  <= '0;
			last_q     <= 1'b0;
			drop_q     <= 1'b0;
			first_q    <= 1'b0;
		end else if (cmd.clear) begin
			// The series has ended: the next word starts from the reset state.
			cum_q      <= '0;
			peak_q     <= '0;
			peak_idx_q <= '0;
			deep_q     <= '0;
			trough_q   <= '0;
			ppos_q     <= '0;
			plevel_q   <= '0;
			rec_vld_q  <= 1'b0;
			total_q    <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			last_dd_q  <= '0;
		end else if (cmd.accept) begin
			last_q  <= in_data.is_last;
			drop_q  <= (cnt_q == CNT_W'(MAX_OBS));
			first_q <= (cnt_q == '0);
			if (cnt_q == CNT_W'(MAX_OBS)) begin
				ovf_q <= 1'b1;
			end else if (cnt_q == '0) begin
				cum_q <= ret_ext;
			end else begin
				cum_q <= cum_q + ret_ext;
			end
		end else if (cmd.update && !drop_q) begin
			if (ge) begin
				peak_q     <= cum_q;
				peak_idx_q <= cnt_q;
			end
			if (first_q) begin
				plevel_q <= cum_q;
			end
			last_dd_q <= dd;
			total_q   <= total_q + {{(TOT_W-VAL_W){dd[VAL_W-1]}}, dd};
			// A new deepest drawdown never coincides with a new peak, so the
			// stored peak is still the one before this trough.
			if (deeper) begin
				deep_q    <= mag;
				trough_q  <= cnt_q;
				ppos_q    <= peak_idx_q;
				plevel_q  <= peak_q;
				rec_vld_q <= 1'b0;
			end else if (regained) begin
				rec_q     <= cnt_q;
				rec_vld_q <= 1'b1;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.drawdown          <= last_dd_q;
			out_q.worst_drawdown    <= deep_q;
			out_q.mean_drawdown     <= cmd.with_avg ? quotient[VAL_W-1:0] : '0;
			out_q.peak_index        <= ppos_q;
			out_q.trough_index      <= trough_q;
			out_q.recovery_index    <= rec_vld_q ? rec_q : cnt_q;
			out_q.drawdown_duration <= (trough_q > ppos_q) ? (trough_q - ppos_q) : '0;
			out_q.sample_count      <= cnt_q;
			out_q.status            <= status;
			out_q.last_result       <= last_q;
		end
	end

	assign sts.last     = last_q;
	assign sts.div_done = div_done;
	assign out_data     = out_q;

endmodule

`default_nettype wire

// ===== src/ddt_ctrl.sv =====
// Controller of the drawdown tracker: sequences accept, update, result load
// and the divide for the last word. Depends on ddt_pkg.
`default_nettype none

module ddt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire ddt_pkg::ctrl_sts_t sts,
	output ddt_pkg::ctrl_cmd_t      cmd
);
	import ddt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_RES  = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	// A word is taken only when the output register is empty or emptying now,
	// so the result slot is free when this word's result is loaded.
	assign in_stall = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall));
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = accept;
				if (accept) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_RES;
			end
			ST_RES: begin
				if (sts.last) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.load_out = 1'b1;
					cmd.with_avg = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/drawdown_tracker_core.sv =====
// Drawdown tracker top level: joins the controller and the datapath.
// Depends on ddt_pkg, ddt_ctrl and ddt_dp.
//
// Input channel in_valid/in_stall/in_data carries one Q8.24 return per word
// together with the end-of-series mark. Every accepted word yields exactly one
// result word on out_valid/out_stall/out_data, in order.
// A word that does not end the series is handled in order once it is
// accepted: the accept adds the return to the cumulative sum, the update
// step updates peak, trough and recovery, and the result step loads the
// output register. The next word can be taken once that result is in the
// output register, so the block works on one word at a time.
// The word that ends the series also runs the restoring divider for the
// average drawdown, one quotient bit per cycle over 57 bits, before its
// result is loaded. The series state then returns to its reset values and
// the next word begins a new series.
// When the receiver stalls, the result holds in the output register and no
// further word is taken until the register is emptied.
// Reset clears all control and series state at once; there is no clearing
// pass, and in_stall is low as soon as reset is released.
`default_nettype none

module drawdown_tracker_core #(
	parameter int MAX_OBS = ddt_pkg::MAX_OBS_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ddt_pkg::in_word_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ddt_pkg::out_word_t     out_data
);
	import ddt_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	ddt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ddt_dp #(
		.MAX_OBS (MAX_OBS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ===== src/ddt_checker.sv =====
// Port-level checks of the drawdown tracker and the bind that attaches them.
// Depends on ddt_pkg and drawdown_tracker_core_defines.svh.
`default_nettype none
`include "drawdown_tracker_core_defines.svh"

module ddt_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire ddt_pkg::in_word_t in_data,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire ddt_pkg::out_word_t out_data
);
	import ddt_pkg::*;

	// Each word is worked on alone, so the input closes right after a take.
	`DDT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && !in_stall, in_stall, "word taken while busy")

	// A word that does not end the series has its result ready after the update and result states.
	`DDT_ASSERT(a_result_latency, clk, arst_n, (in_valid && !in_stall && !in_data.is_last) |-> ##3 out_valid, "result late")

	// A final result always covers at least one accepted return.
	`DDT_ASSERT(a_last_has_count, clk, arst_n, (out_valid && out_data.last_result) |-> (out_data.sample_count != '0), "empty final result")

	`DDT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind drawdown_tracker_core ddt_checker u_ddt_checker (.*);

`default_nettype wire

// ===== test/drawdown_tracker_core_tb.sv =====
// Self-checking testbench of drawdown_tracker_core: directed series and long
// random series, with random idling on both sides.
// Depends on ddt_pkg and the drawdown_tracker_core RTL.
`default_nettype none

module drawdown_tracker_core_tb;

	import ddt_pkg::*;

	localparam int OBS_LIMIT   = MAX_OBS_DEFAULT;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 80;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;

	drawdown_tracker_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mirror of the series state.
	longint      cum_sum;
	longint      peak_run;
	int unsigned peak_run_idx;
	longint      worst_dd;
	int unsigned trough_at;
	int unsigned peak_at;
	longint      peak_lvl;
	int unsigned recov_at;
	bit          recov_set;
	longint      dd_sum;
	int unsigned n_seen;
	bit          ovf_flag;
	bit          series_ended;
	longint      prev_dd;

	out_word_t   expected_results[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          cycle_count = 0;
	bit          idle_on = 1'b0;
	int          stall_left = 0;

	task automatic clear_series();
		cum_sum      = 0;
		peak_run     = 0;
		peak_run_idx = 0;
		worst_dd     = 0;
		trough_at    = 0;
		peak_at      = 0;
		peak_lvl     = 0;
		recov_at     = 0;
		recov_set    = 1'b0;
		dd_sum       = 0;
		n_seen       = 0;
		ovf_flag     = 1'b0;
		series_ended = 1'b0;
		prev_dd      = 0;
	endtask

	task automatic predict_drawdown(input in_word_t w, output out_word_t r);
		longint            ret;
		longint            dd;
		longint unsigned   neg_total;
		longint unsigned   avg;
		int unsigned       idx;
		int unsigned       recovery;
		int unsigned       duration;
		if (series_ended)
			clear_series();
		avg = 0;
		if (n_seen < OBS_LIMIT) begin
			idx = n_seen;
			ret = $signed(w.sample_return);
			if (idx == 0) begin
				cum_sum      = ret;
				peak_run     = ret;
				peak_run_idx = 0;
				peak_lvl     = ret;
				peak_at      = 0;
				trough_at    = 0;
				worst_dd     = 0;
				recov_set    = 1'b0;
			end else begin
				cum_sum = cum_sum + ret;
				if (cum_sum >= peak_run) begin
					peak_run     = cum_sum;
					peak_run_idx = idx;
				end
			end
			dd      = cum_sum - peak_run;
			dd_sum  = dd_sum + dd;
			prev_dd = dd;
			// Only a strictly deeper drawdown moves the trough; ties keep the first.
			if (-dd > worst_dd) begin
				worst_dd  = -dd;
				trough_at = idx;
				peak_at   = peak_run_idx;
				peak_lvl  = peak_run;
				recov_set = 1'b0;
			end else if (!recov_set && idx > trough_at && cum_sum >= peak_lvl) begin
				recov_at  = idx;
				recov_set = 1'b1;
			end
			n_seen = idx + 1;
		end else begin
			ovf_flag = 1'b1;
		end

		recovery = recov_set ? recov_at : n_seen;
		duration = (trough_at > peak_at) ? trough_at - peak_at : 0;
		if (w.is_last && n_seen != 0) begin
			neg_total = -dd_sum;
			avg = neg_total / longint'(n_seen);
		end

		r.drawdown          = prev_dd[VAL_W-1:0];
		r.worst_drawdown    = worst_dd[VAL_W-1:0];
		r.mean_drawdown     = avg[VAL_W-1:0];
		r.peak_index        = peak_at[CNT_W-1:0];
		r.trough_index      = trough_at[CNT_W-1:0];
		r.recovery_index    = recovery[CNT_W-1:0];
		r.drawdown_duration = duration[CNT_W-1:0];
		r.sample_count      = n_seen[CNT_W-1:0];
		if (ovf_flag)
			r.status = STATUS_OVERFLOW;
		else if (n_seen < 2)
			r.status = STATUS_SHORT;
		else
			r.status = STATUS_OK;
		r.last_result  = w.is_last;
		series_ended   = w.is_last;
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// Result side: compare every accepted word with the oldest prediction.
	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = expected_results.pop_front();
				check_field("drawdown", out_data.drawdown, want.drawdown);
				check_field("worst_drawdown", out_data.worst_drawdown,
					want.worst_drawdown);
				check_field("mean_drawdown", out_data.mean_drawdown,
					want.mean_drawdown);
				check_field("peak_index", out_data.peak_index, want.peak_index);
				check_field("trough_index", out_data.trough_index, want.trough_index);
				check_field("recovery_index", out_data.recovery_index,
					want.recovery_index);
				check_field("drawdown_duration", out_data.drawdown_duration,
					want.drawdown_duration);
				check_field("sample_count", out_data.sample_count, want.sample_count);
				check_field("status", out_data.status, want.status);
				check_field("last_result", out_data.last_result, want.last_result);
			end
			results_seen++;
		end
	end

	// Receiver idling in random bursts, which start only while idle_on is set.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(1, 9) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("drawdown_tracker_core_tb NOT OK");
		$finish;
	end

	// Called at a rising edge; returns at the edge where the word was taken.
	// Valid is left high so that back-to-back words need no second assignment.
	task automatic send_word(input logic [RET_W-1:0] ret, input logic last);
		in_word_t  w;
		out_word_t r;
		w.sample_return = ret;
		w.is_last       = last;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (in_stall);
		predict_drawdown(w, r);
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	function automatic logic [RET_W-1:0] pick_return();
		case ($urandom_range(0, 11)) inside
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3, 4:    return $urandom;
			// Mostly returns within plus or minus one, so peaks are regained often.
			default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		endcase
	endfunction

	task automatic test_lone_word();
		send_word(32'h7FFF_FFFF, 1'b1);
	endtask

	task automatic test_extreme_returns();
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h8000_0000, 1'b1);
	endtask

	task automatic test_no_drawdown();
		send_word(32'h0100_0000, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b1);
	endtask

	// A dip, its recovery, an equal dip that must not move the trough,
	// a new peak and then a deeper dip.
	task automatic test_recovery_and_ties();
		send_word(32'h0000_0100, 1'b0);
		send_word(32'hFFFF_FF80, 1'b0);
		send_word(32'h0000_0080, 1'b0);
		send_word(32'hFFFF_FF80, 1'b0);
		send_word(32'h0000_0100, 1'b0);
		send_word(32'hFFFF_FE00, 1'b1);
	endtask

	task automatic test_drain_pause();
		send_word(32'h0080_0000, 1'b0);
		send_word(32'hFF00_0000, 1'b0);
		wait_drained();
		send_word(32'h0100_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_series(input int n_items, input bit idling);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			idle_on = idling && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(1, 120);
			else
				len = $urandom_range(1, 30);
			for (int i = 0; i < len; i++)
				send_word(pick_return(), i == len - 1);
			sent += len;
			if (idling && $urandom_range(0, 9) == 0)
				wait_drained();
		end
		idle_on = 1'b0;
	endtask

	initial begin
		clear_series();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		test_lone_word();
		test_extreme_returns();
		test_no_drawdown();
		test_recovery_and_ties();
		test_drain_pause();
		test_random_series(1350, 1'b1);
		test_random_series(150, 1'b0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("drawdown_tracker_core_tb OK");
		else
			$display("drawdown_tracker_core_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/ddt_pkg.sv
src/ddt_div.sv
src/ddt_dp.sv
src/ddt_ctrl.sv
src/drawdown_tracker_core.sv
src/ddt_checker.sv
test/drawdown_tracker_core_tb.sv
